// ----- sv/best_fit_region_allocator_defines.svh -----
// Assertion macros for the region allocator
`ifndef BEST_FIT_REGION_ALLOCATOR_DEFINES_SVH
`define BEST_FIT_REGION_ALLOCATOR_DEFINES_SVH
`ifndef ASSERT_OFF
`define BFRA_ASSERT_IMP(label, clk, rst_n, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
`define BFRA_ASSERT_NXT(label, clk, rst_n, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`else
`define BFRA_ASSERT_IMP(label, clk, rst_n, a, c, msg)
`define BFRA_ASSERT_NXT(label, clk, rst_n, a, c, msg)
`endif
`endif

// ----- sv/bfra_pkg.sv -----
package bfra_pkg;

  localparam int unsigned SIZE_W = 21;
  localparam int unsigned ADDR_W = 20;

  typedef enum logic [1:0] {
    OP_REQUEST = 2'd0,
    OP_RELEASE = 2'd1,
    OP_CLEAR   = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_HOLE = 2'd1,
    ST_NO_BLK  = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]        operation;
    logic [7:0]        process_id;
    logic [SIZE_W-1:0] size;
  } in_word_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [ADDR_W-1:0] start_address;
    logic [SIZE_W-1:0] allocated_total;
  } out_word_t;

  // controller -> datapath
  typedef struct packed {
    logic start;      // latch input word, reset scan
    logic clr_step;   // clear one hole entry / block entry
    logic hscan;      // scan one hole entry
    logic bscan;      // scan one block entry
    logic commit_req; // apply request update
    logic commit_rel; // apply release update
    logic finish;     // load output register
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic hlast;   // hole index at last entry
    logic blast;   // block index at last entry
    logic is_req;
    logic is_rel;
    logic is_clr;
    logic fail;    // request/release fails after scan
  } dp_sts_t;

endpackage

// ----- sv/bfra_ctrl.sv -----
module bfra_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  bfra_pkg::dp_sts_t sts,
  output bfra_pkg::dp_cmd_t cmd
);

  typedef enum logic [8:0] {
    S_INIT  = 9'b0_0000_0001,
    S_IDLE  = 9'b0_0000_0010,
    S_DEC   = 9'b0_0000_0100,
    S_BSCAN = 9'b0_0000_1000,
    S_HSCAN = 9'b0_0001_0000,
    S_WAIT  = 9'b0_0010_0000,
    S_COMM  = 9'b0_0100_0000,
    S_CLR   = 9'b0_1000_0000,
    S_DONE  = 9'b1_0000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   is_rel_r, is_rel_nxt;

  // the output register lets a new word in while the last result waits
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  // sequencer: release scans blocks then holes, request scans holes then blocks
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    is_rel_nxt    = is_rel_r;
    cmd           = '0;
    case (state_r)
      S_INIT: begin
        cmd.clr_step = 1'b1;
        if (sts.hlast) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid && !in_stall) begin
          cmd.start = 1'b1;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        is_rel_nxt = sts.is_rel;
        if (sts.is_clr) state_nxt = S_CLR;
        else if (sts.is_rel) state_nxt = S_BSCAN;
        else if (sts.is_req) state_nxt = S_HSCAN;
        else state_nxt = S_DONE;
      end
      S_BSCAN: begin
        cmd.bscan = 1'b1;
        if (sts.blast) state_nxt = is_rel_r ? S_HSCAN : S_WAIT;
      end
      S_HSCAN: begin
        cmd.hscan = 1'b1;
        if (sts.hlast) state_nxt = is_rel_r ? S_WAIT : S_BSCAN;
      end
      // the last table read is checked in the cycle after it is issued
      S_WAIT: begin
        state_nxt = S_COMM;
      end
      S_COMM: begin
        if (!sts.fail) begin
          cmd.commit_req = !is_rel_r;
          cmd.commit_rel = is_rel_r;
        end
        state_nxt = S_DONE;
      end
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (sts.hlast) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!(out_valid_r && out_stall)) begin
          cmd.finish    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_INIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      out_valid_r <= 1'b0;
      is_rel_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      is_rel_r    <= is_rel_nxt;
    end
  end

endmodule

// ----- sv/bfra_dp.sv -----
module bfra_dp #(
  parameter int unsigned BLOCK_SLOTS = 64
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  bfra_pkg::dp_cmd_t                cmd,
  output bfra_pkg::dp_sts_t                sts,
  input  bfra_pkg::in_word_t               in_word,
  input  logic                             cfg_write,
  input  logic [bfra_pkg::SIZE_W-1:0]      cfg_data,
  output bfra_pkg::out_word_t              out_word
);

  localparam int unsigned SPACE_BITS = bfra_pkg::ADDR_W;
  localparam int unsigned HOLES = BLOCK_SLOTS + 1;
  localparam int unsigned HW    = $clog2(HOLES);
  localparam int unsigned BW    = $clog2(BLOCK_SLOTS);
  localparam int unsigned LW    = SPACE_BITS + 1;
  localparam logic [LW-1:0] LIMIT = LW'(1) << SPACE_BITS;

  // state storage: valid bits in flops, entry fields in memories
  logic [HOLES-1:0]           hv_r;
  logic [SPACE_BITS-1:0]      hs_r [HOLES];
  logic [LW-1:0]              hl_r [HOLES];
  logic [BLOCK_SLOTS-1:0]     bv_r;
  logic [7:0]                 bo_r [BLOCK_SLOTS];
  logic [SPACE_BITS-1:0]      bs_r [BLOCK_SLOTS];
  logic [LW-1:0]              bl_r [BLOCK_SLOTS];
  logic [LW-1:0]              alloc_r;
  logic [bfra_pkg::SIZE_W-1:0] total_r;

  // registered table reads at the scan index
  logic                       hscan_d_r, bscan_d_r;
  logic [HW-1:0]              hidx_d_r;
  logic [BW-1:0]              bidx_d_r;
  logic                       hv_d_r, bv_d_r;
  logic [SPACE_BITS-1:0]      hs_q_r, bs_q_r;
  logic [LW-1:0]              hl_q_r, bl_q_r;
  logic [7:0]                 bo_q_r;

  bfra_pkg::in_word_t         req_r;
  logic [HW-1:0]              hi_r;
  logic [BW-1:0]              bi_r;
  logic                       best_ok_r, slot_ok_r, blk_ok_r, left_ok_r, right_ok_r;
  logic [HW-1:0]              best_r, left_r, right_r, free_r;
  logic                       free_ok_r;
  logic [LW-1:0]              best_len_r, left_len_r, right_len_r;
  logic [SPACE_BITS-1:0]      best_start_r;
  logic [BW-1:0]              slot_r, blk_r;
  logic [SPACE_BITS-1:0]      bst_r;
  logic [LW-1:0]              blen_r;
  logic [SPACE_BITS:0]        bend_r;
  bfra_pkg::out_word_t        out_r;

  logic [LW-1:0]              size_w, lim_w, tot_ext;
  logic [SPACE_BITS:0]        hend;
  logic [LW-1:0]              rem;
  bfra_pkg::status_t          fin_status;
  logic [bfra_pkg::ADDR_W-1:0] fin_addr;

  assign tot_ext = LW'(total_r);
  assign size_w  = LW'(req_r.size);
  assign lim_w   = (tot_ext == '0) ? LW'(1) : ((tot_ext > LIMIT) ? LIMIT : tot_ext);
  assign hend    = {1'b0, hs_q_r} + hl_q_r;
  assign rem     = best_len_r - size_w;

  assign sts.hlast  = (hi_r == HW'(HOLES - 1));
  assign sts.blast  = (bi_r == BW'(BLOCK_SLOTS - 1));
  assign sts.is_req = (req_r.operation == bfra_pkg::OP_REQUEST);
  assign sts.is_rel = (req_r.operation == bfra_pkg::OP_RELEASE);
  assign sts.is_clr = (req_r.operation == bfra_pkg::OP_CLEAR);
  assign sts.fail   = sts.is_rel ? !blk_ok_r : (!best_ok_r || !slot_ok_r);
  assign out_word   = out_r;

  // result fields for the word in hand
  always_comb begin
    fin_status = bfra_pkg::ST_OK;
    fin_addr   = '0;
    if (sts.is_req) begin
      if (!best_ok_r) fin_status = bfra_pkg::ST_NO_HOLE;
      else if (!slot_ok_r) fin_status = bfra_pkg::ST_FULL;
      else fin_addr = bfra_pkg::ADDR_W'(bst_r);
    end else if (sts.is_rel) begin
      if (!blk_ok_r) fin_status = bfra_pkg::ST_NO_BLK;
      else fin_addr = bfra_pkg::ADDR_W'(bst_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r   <= bfra_pkg::SIZE_W'(1048576);
      hi_r      <= '0;
      bi_r      <= '0;
      alloc_r   <= '0;
      hv_r      <= '0;
      bv_r      <= '0;
      hscan_d_r <= 1'b0;
      bscan_d_r <= 1'b0;
    end else begin
      if (cfg_write) total_r <= cfg_data;
      // one read per table per cycle, checked next cycle
      hscan_d_r <= cmd.hscan;
      bscan_d_r <= cmd.bscan;
      hidx_d_r  <= hi_r;
      bidx_d_r  <= bi_r;
      hv_d_r    <= hv_r[hi_r];
      bv_d_r    <= bv_r[bi_r];
      hs_q_r    <= hs_r[hi_r];
      hl_q_r    <= hl_r[hi_r];
      bo_q_r    <= bo_r[bi_r];
      bs_q_r    <= bs_r[bi_r];
      bl_q_r    <= bl_r[bi_r];
      if (cmd.start) begin
        req_r      <= in_word;
        hi_r       <= '0;
        bi_r       <= '0;
        best_ok_r  <= 1'b0;
        slot_ok_r  <= 1'b0;
        blk_ok_r   <= 1'b0;
        left_ok_r  <= 1'b0;
        right_ok_r <= 1'b0;
        free_ok_r  <= 1'b0;
      end
      // clear sweep, one hole and one block entry a cycle
      if (cmd.clr_step) begin
        hv_r[hi_r] <= (hi_r == '0);
        hs_r[hi_r] <= '0;
        hl_r[hi_r] <= (hi_r == '0) ? lim_w : '0;
        if (!sts.blast) bi_r <= bi_r + BW'(1);
        bv_r[bi_r] <= 1'b0;
        alloc_r    <= '0;
        hi_r       <= sts.hlast ? '0 : hi_r + HW'(1);
      end
      if (cmd.hscan) begin
        if (!sts.hlast) hi_r <= hi_r + HW'(1);
      end
      if (cmd.bscan) begin
        if (!sts.blast) bi_r <= bi_r + BW'(1);
      end
      // hole check: best fit for request, neighbors and free slot for release
      if (hscan_d_r) begin
        if (hv_d_r) begin
          if (req_r.size != '0 && hl_q_r >= size_w &&
              (!best_ok_r || hl_q_r <= best_len_r)) begin
            best_ok_r    <= 1'b1;
            best_r       <= hidx_d_r;
            best_len_r   <= hl_q_r;
            best_start_r <= hs_q_r;
          end
          if (hend == {1'b0, bst_r}) begin
            left_ok_r  <= 1'b1;
            left_r     <= hidx_d_r;
            left_len_r <= hl_q_r;
          end
          if ({1'b0, hs_q_r} == bend_r) begin
            right_ok_r  <= 1'b1;
            right_r     <= hidx_d_r;
            right_len_r <= hl_q_r;
          end
        end else if (!free_ok_r) begin
          free_ok_r <= 1'b1;
          free_r    <= hidx_d_r;
        end
      end
      // block check: lowest free slot for request, last owner match for release
      if (bscan_d_r) begin
        if (!bv_d_r && !slot_ok_r) begin
          slot_ok_r <= 1'b1;
          slot_r    <= bidx_d_r;
        end
        if (bv_d_r && bo_q_r == req_r.process_id) begin
          blk_ok_r <= 1'b1;
          blk_r    <= bidx_d_r;
          bst_r    <= bs_q_r;
          blen_r   <= bl_q_r;
          bend_r   <= {1'b0, bs_q_r} + bl_q_r;
        end
      end
      if (cmd.commit_req) begin
        bv_r[slot_r] <= 1'b1;
        bo_r[slot_r] <= req_r.process_id;
        bs_r[slot_r] <= best_start_r;
        bl_r[slot_r] <= size_w;
        bst_r        <= best_start_r;
        hl_r[best_r] <= rem;
        if (rem == '0) begin
          hv_r[best_r] <= 1'b0;
          hs_r[best_r] <= '0;
        end else begin
          hs_r[best_r] <= best_start_r + SPACE_BITS'(req_r.size);
        end
        alloc_r <= alloc_r + size_w;
      end
      if (cmd.commit_rel) begin
        if (left_ok_r) begin
          if (right_ok_r) begin
            hl_r[left_r]  <= left_len_r + blen_r + right_len_r;
            hv_r[right_r] <= 1'b0;
            hs_r[right_r] <= '0;
            hl_r[right_r] <= '0;
          end else begin
            hl_r[left_r] <= left_len_r + blen_r;
          end
        end else if (right_ok_r) begin
          hs_r[right_r] <= bst_r;
          hl_r[right_r] <= right_len_r + blen_r;
        end else if (free_ok_r) begin
          hv_r[free_r] <= 1'b1;
          hs_r[free_r] <= bst_r;
          hl_r[free_r] <= blen_r;
        end
        alloc_r     <= alloc_r - blen_r;
        bv_r[blk_r] <= 1'b0;
      end
      if (cmd.finish) begin
        out_r.allocated_total <= bfra_pkg::SIZE_W'(alloc_r);
        out_r.start_address   <= fin_addr;
        out_r.status          <= fin_status;
      end
    end
  end

endmodule

// ----- sv/best_fit_region_allocator.sv -----
// Best-fit contiguous region allocator.
// Input channel in_valid/in_stall/in_word carries an operation: request
// (size units for an owner), release (the owner's last block) or clear.
// Every input word yields exactly one result word on out_valid/out_stall/
// out_word: status, start address and the allocated total afterwards.
// One word is worked on at a time. A request or release walks the hole
// table (BLOCK_SLOTS+1 entries) and the block table (BLOCK_SLOTS entries)
// one entry per cycle through registered reads; the next word can be taken
// as soon as the result is valid. A clear sweeps both tables; operation 3
// goes straight to its result.
// After reset the block sweeps both tables with in_stall high, leaving one
// hole of total_size units.
// cfg_we/cfg_data writes total_size; it takes effect at the next clear.
// A result held by out_stall stays on out_word; the next word is accepted
// but the following result waits until the output register frees up.
`include "best_fit_region_allocator_defines.svh"
module best_fit_region_allocator #(
  parameter int unsigned BLOCK_SLOTS = 64
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  bfra_pkg::in_word_t           in_word,
  output logic                         out_valid,
  input  logic                         out_stall,
  output bfra_pkg::out_word_t          out_word,
  input  logic                         cfg_we,
  input  logic [bfra_pkg::SIZE_W-1:0]  cfg_data
);

  bfra_pkg::dp_cmd_t cmd;
  bfra_pkg::dp_sts_t sts;

  bfra_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  bfra_dp #(
    .BLOCK_SLOTS (BLOCK_SLOTS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_word   (in_word),
    .cfg_write (cfg_we),
    .cfg_data  (cfg_data),
    .out_word  (out_word)
  );

  // a word is never accepted while a command other than start is active
  `BFRA_ASSERT_IMP(a_accept_idle, clk, rst_n, in_valid && !in_stall, !(cmd.hscan || cmd.bscan || cmd.clr_step), "accept while busy")
  // the two commit strobes never fire together
  `BFRA_ASSERT_IMP(a_one_commit, clk, rst_n, cmd.commit_req || cmd.commit_rel, !(cmd.commit_req && cmd.commit_rel), "double commit")
  // finish raises the output valid
  `BFRA_ASSERT_NXT(a_finish_valid, clk, rst_n, cmd.finish, out_valid, "result lost")

endmodule

// ----- tb/sv/best_fit_region_allocator_test.sv -----
module best_fit_region_allocator_test;

  localparam int unsigned SLOTS = 64;
  localparam int unsigned HOLES = SLOTS + 1;
  localparam int unsigned SPACE_MAX = 1 << 20;
  localparam int unsigned DRAIN_CYCLES = 200;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  bfra_pkg::in_word_t in_word = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  bfra_pkg::out_word_t out_word;
  logic cfg_we = 1'b0;
  logic [bfra_pkg::SIZE_W-1:0] cfg_data = '0;

  best_fit_region_allocator dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow allocator state
  bit hole_used[HOLES];
  int unsigned hole_base[HOLES];
  int unsigned hole_len[HOLES];
  bit blk_used[SLOTS];
  int unsigned blk_owner[SLOTS];
  int unsigned blk_base[SLOTS];
  int unsigned blk_len[SLOTS];
  int unsigned units_taken;
  int unsigned space_reg;

  bfra_pkg::out_word_t results_due[$];
  int unsigned fails = 0;
  int unsigned burst_left = 0;

  // clamp the register value to a usable space size
  function automatic int unsigned space_units();
    if (space_reg < 1) return 1;
    if (space_reg > SPACE_MAX) return SPACE_MAX;
    return space_reg;
  endfunction

  function automatic void wipe_space();
    for (int i = 0; i < HOLES; i++) begin
      hole_used[i] = 0; hole_base[i] = 0; hole_len[i] = 0;
    end
    for (int i = 0; i < SLOTS; i++) begin
      blk_used[i] = 0; blk_owner[i] = 0; blk_base[i] = 0; blk_len[i] = 0;
    end
    hole_used[0] = 1;
    hole_len[0] = space_units();
    units_taken = 0;
  endfunction

  // best fit: smallest hole that fits, highest index on ties
  function automatic bfra_pkg::status_t take_block(int unsigned owner, int unsigned sz,
                                                   ref int unsigned addr);
    int best;
    int slot;
    best = -1;
    slot = -1;
    for (int i = 0; i < HOLES; i++)
      if (hole_used[i] && sz != 0 && hole_len[i] >= sz &&
          (best < 0 || hole_len[i] <= hole_len[best]))
        best = i;
    if (best < 0) return bfra_pkg::ST_NO_HOLE;
    for (int i = SLOTS - 1; i >= 0; i--)
      if (!blk_used[i]) slot = i;
    if (slot < 0) return bfra_pkg::ST_FULL;
    blk_used[slot] = 1;
    blk_owner[slot] = owner;
    blk_base[slot] = hole_base[best];
    blk_len[slot] = sz;
    addr = hole_base[best];
    hole_base[best] += sz;
    hole_len[best] -= sz;
    if (hole_len[best] == 0) begin
      hole_used[best] = 0;
      hole_base[best] = 0;
    end
    units_taken += sz;
    return bfra_pkg::ST_OK;
  endfunction

  // free the owner's highest block and merge with neighbors
  function automatic bfra_pkg::status_t free_block(int unsigned owner,
                                                   ref int unsigned addr);
    int b;
    int lft;
    int rgt;
    int f;
    int unsigned s;
    int unsigned e;
    b = -1; lft = -1; rgt = -1; f = -1;
    for (int i = 0; i < SLOTS; i++)
      if (blk_used[i] && blk_owner[i] == owner) b = i;
    if (b < 0) return bfra_pkg::ST_NO_BLK;
    s = blk_base[b];
    e = s + blk_len[b];
    for (int i = 0; i < HOLES; i++) begin
      if (hole_used[i]) begin
        if (hole_base[i] + hole_len[i] == s) lft = i;
        if (hole_base[i] == e) rgt = i;
      end
    end
    if (lft >= 0) begin
      hole_len[lft] += blk_len[b];
      if (rgt >= 0) begin
        hole_len[lft] += hole_len[rgt];
        hole_used[rgt] = 0; hole_base[rgt] = 0; hole_len[rgt] = 0;
      end
    end else if (rgt >= 0) begin
      hole_base[rgt] = s;
      hole_len[rgt] += blk_len[b];
    end else begin
      for (int i = HOLES - 1; i >= 0; i--)
        if (!hole_used[i]) f = i;
      if (f >= 0) begin
        hole_used[f] = 1; hole_base[f] = s; hole_len[f] = blk_len[b];
      end
    end
    units_taken -= blk_len[b];
    blk_used[b] = 0;
    addr = s;
    return bfra_pkg::ST_OK;
  endfunction

  function automatic bfra_pkg::out_word_t apply_word(bfra_pkg::in_word_t w);
    bfra_pkg::out_word_t r;
    int unsigned addr;
    bfra_pkg::status_t st;
    addr = 0;
    st = bfra_pkg::ST_OK;
    case (bfra_pkg::op_t'(w.operation))
      bfra_pkg::OP_REQUEST: st = take_block(32'(w.process_id), 32'(w.size), addr);
      bfra_pkg::OP_RELEASE: st = free_block(32'(w.process_id), addr);
      bfra_pkg::OP_CLEAR: wipe_space();
      default: ;
    endcase
    r.status = st;
    r.start_address = addr[bfra_pkg::ADDR_W-1:0];
    r.allocated_total = units_taken[bfra_pkg::SIZE_W-1:0];
    return r;
  endfunction

  // send one word; typed result replaces the predicted one when given
  task automatic send_word(bfra_pkg::in_word_t w, bit typed, bfra_pkg::out_word_t typed_res);
    bfra_pkg::out_word_t r;
    @(negedge clk);
    in_valid <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (in_stall);
    r = apply_word(w);
    results_due.push_back(typed ? typed_res : r);
    if (burst_left == 0) begin
      burst_left = $urandom_range(0, 3) == 0 ? 40 : $urandom_range(1, 12);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat ($urandom_range(0, 9)) @(negedge clk);
    end else begin
      burst_left--;
    end
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    wait (results_due.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_space(logic [bfra_pkg::SIZE_W-1:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    space_reg = 32'(v);
  endtask

  function automatic bfra_pkg::in_word_t mk(bfra_pkg::op_t op, int unsigned pid,
                                            int unsigned sz);
    bfra_pkg::in_word_t w;
    w.operation = op;
    w.process_id = pid[7:0];
    w.size = sz[bfra_pkg::SIZE_W-1:0];
    return w;
  endfunction

  function automatic bfra_pkg::out_word_t res(bfra_pkg::status_t st, int unsigned a,
                                              int unsigned t);
    bfra_pkg::out_word_t r;
    r.status = st;
    r.start_address = a[bfra_pkg::ADDR_W-1:0];
    r.allocated_total = t[bfra_pkg::SIZE_W-1:0];
    return r;
  endfunction

  // mostly well-formed traffic over a few owners, some noise
  function automatic bfra_pkg::in_word_t random_word();
    bfra_pkg::in_word_t w;
    int unsigned pick;
    int unsigned sp;
    sp = space_units();
    pick = $urandom_range(0, 99);
    w.process_id = $urandom_range(0, 9) == 0 ? 8'($urandom_range(0, 255))
                                              : 8'($urandom_range(0, 11));
    w.size = bfra_pkg::SIZE_W'($urandom);
    if (pick < 55) begin
      w.operation = bfra_pkg::OP_REQUEST;
      case ($urandom_range(0, 9))
        0: w.size = bfra_pkg::SIZE_W'($urandom);
        1: w.size = '0;
        2: w.size = bfra_pkg::SIZE_W'($urandom_range(1, sp));
        default: w.size = bfra_pkg::SIZE_W'($urandom_range(1, sp > 16 ? sp / 16 : 1));
      endcase
    end else if (pick < 93) begin
      w.operation = bfra_pkg::OP_RELEASE;
    end else if (pick < 97) begin
      w.operation = bfra_pkg::OP_CLEAR;
    end else begin
      w.operation = bfra_pkg::OP_NONE;
    end
    return w;
  endfunction

  // result checker
  always @(posedge clk) begin
    bfra_pkg::out_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (results_due.size() == 0) begin
        $error("result word with nothing expected");
        fails++;
      end else begin
        want = results_due.pop_front();
        if (out_word.status !== want.status) begin
          $error("status expected %0d got %0d", want.status, out_word.status);
          fails++;
        end
        if (out_word.start_address !== want.start_address) begin
          $error("start_address expected %0d got %0d", want.start_address,
                 out_word.start_address);
          fails++;
        end
        if (out_word.allocated_total !== want.allocated_total) begin
          $error("allocated_total expected %0d got %0d", want.allocated_total,
                 out_word.allocated_total);
          fails++;
        end
      end
    end
  end

  // receiver stall pattern: free runs, light and heavy stalling
  initial begin
    int unsigned mode;
    mode = 0;
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 127) == 0) mode = $urandom_range(0, 2);
      case (mode)
        0: out_stall <= 1'b0;
        1: out_stall <= $urandom_range(0, 3) == 0;
        default: out_stall <= $urandom_range(0, 3) != 0;
      endcase
    end
  end

  typedef struct {
    bfra_pkg::in_word_t w;
    bit typed;
    bfra_pkg::out_word_t r;
  } step_row_t;

  initial begin
    step_row_t rows[$];
    logic [bfra_pkg::SIZE_W-1:0] spaces[$];
    int unsigned per_phase;
    space_reg = SPACE_MAX;
    wipe_space();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed words
    rows.push_back('{mk(bfra_pkg::OP_REQUEST, 5, 0), 1, res(bfra_pkg::ST_NO_HOLE, 0, 0)});
    rows.push_back('{mk(bfra_pkg::OP_RELEASE, 9, 0), 1, res(bfra_pkg::ST_NO_BLK, 0, 0)});
    rows.push_back('{mk(bfra_pkg::OP_REQUEST, 255, 2097151), 1,
                     res(bfra_pkg::ST_NO_HOLE, 0, 0)});
    rows.push_back('{mk(bfra_pkg::OP_REQUEST, 0, SPACE_MAX), 1,
                     res(bfra_pkg::ST_OK, 0, SPACE_MAX)});
    rows.push_back('{mk(bfra_pkg::OP_REQUEST, 1, 1), 1,
                     res(bfra_pkg::ST_NO_HOLE, 0, SPACE_MAX)});
    rows.push_back('{mk(bfra_pkg::OP_RELEASE, 0, 0), 1, res(bfra_pkg::ST_OK, 0, 0)});
    rows.push_back('{mk(bfra_pkg::OP_NONE, 170, 1398101), 1, res(bfra_pkg::ST_OK, 0, 0)});
    rows.push_back('{mk(bfra_pkg::OP_REQUEST, 1, 100), 1, res(bfra_pkg::ST_OK, 0, 100)});
    rows.push_back('{mk(bfra_pkg::OP_CLEAR, 85, 699050), 1, res(bfra_pkg::ST_OK, 0, 0)});
    // fragments, isolated release, merges and ties
    rows.push_back('{mk(bfra_pkg::OP_REQUEST, 1, 10), 0, '0});
    rows.push_back('{mk(bfra_pkg::OP_REQUEST, 2, 20), 0, '0});
    rows.push_back('{mk(bfra_pkg::OP_REQUEST, 3, 10), 0, '0});
    rows.push_back('{mk(bfra_pkg::OP_REQUEST, 4, 20), 0, '0});
    rows.push_back('{mk(bfra_pkg::OP_REQUEST, 5, 30), 0, '0});
    rows.push_back('{mk(bfra_pkg::OP_RELEASE, 2, 0), 0, '0});
    rows.push_back('{mk(bfra_pkg::OP_RELEASE, 4, 0), 0, '0});
    rows.push_back('{mk(bfra_pkg::OP_REQUEST, 6, 15), 0, '0});
    rows.push_back('{mk(bfra_pkg::OP_RELEASE, 3, 0), 0, '0});
    rows.push_back('{mk(bfra_pkg::OP_RELEASE, 6, 0), 0, '0});
    rows.push_back('{mk(bfra_pkg::OP_RELEASE, 1, 0), 0, '0});
    rows.push_back('{mk(bfra_pkg::OP_RELEASE, 5, 0), 0, '0});
    rows.push_back('{mk(bfra_pkg::OP_REQUEST, 7, 1), 0, '0});
    rows.push_back('{mk(bfra_pkg::OP_REQUEST, 7, 1), 0, '0});
    rows.push_back('{mk(bfra_pkg::OP_RELEASE, 7, 0), 0, '0});
    foreach (rows[i]) send_word(rows[i].w, rows[i].typed, rows[i].r);

    // fill every block slot, then one more to hit table full
    send_word(mk(bfra_pkg::OP_CLEAR, 0, 0), 0, '0);
    for (int i = 0; i <= SLOTS; i++) send_word(mk(bfra_pkg::OP_REQUEST, i, 1), 0, '0);
    send_word(mk(bfra_pkg::OP_RELEASE, 30, 0), 0, '0);
    send_word(mk(bfra_pkg::OP_REQUEST, 200, 3), 0, '0);
    drain();

    // random phases over several space sizes
    spaces = '{21'd1, 21'd0, 21'd2097151, 21'd300, 21'd1048576, 21'd4096,
               21'd65535, 21'd1398101, 21'd699050};
    per_phase = 1000 / spaces.size();
    foreach (spaces[p]) begin
      write_space(spaces[p]);
      send_word(mk(bfra_pkg::OP_CLEAR, 0, 0), 0, '0);
      repeat (per_phase) send_word(random_word(), 0, '0);
      drain();
    end

    if (results_due.size() != 0) fails += results_due.size();
    if (fails == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #100_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
